// ----- hdl/ecnt_pkg.sv -----
// ----------------------------------------------------------------------------
// Encoder edge counter package
// Word types, register indices, stop causes and default widths shared by the
// encoder edge counter and its checker.
// ----------------------------------------------------------------------------
package ecnt_pkg;

    // Default widths of the internal counters and timers.
    localparam int COUNT_WIDTH_DEFAULT = 16;
    localparam int TIME_WIDTH_DEFAULT  = 32;

    // Widths fixed by the register map and the word fields.
    localparam int CHANNEL_WIDTH = 2;
    localparam int TARGET_WIDTH  = 16;
    localparam int TIMEOUT_WIDTH = 32;
    localparam int WARNING_WIDTH = 24;
    localparam int CFG_WIDTH     = 32;
    localparam int CFG_IDX_WIDTH = 2;
    localparam int EDGES_WIDTH   = 16;
    localparam int CAUSE_WIDTH   = 2;

    // Register indices.
    localparam logic [CFG_IDX_WIDTH-1:0] REG_TRACKED_CHANNEL = 2'd0;
    localparam logic [CFG_IDX_WIDTH-1:0] REG_TARGET_COUNT    = 2'd1;
    localparam logic [CFG_IDX_WIDTH-1:0] REG_TIMEOUT_TICKS   = 2'd2;
    localparam logic [CFG_IDX_WIDTH-1:0] REG_WARNING_TICKS   = 2'd3;

    // Tracked wheel codes.
    localparam logic [CHANNEL_WIDTH-1:0] CHANNEL_LEFT  = 2'd0;
    localparam logic [CHANNEL_WIDTH-1:0] CHANNEL_RIGHT = 2'd1;

    // Stop cause codes.
    localparam logic [CAUSE_WIDTH-1:0] CAUSE_RUNNING = 2'd0;
    localparam logic [CAUSE_WIDTH-1:0] CAUSE_WARNING = 2'd1;
    localparam logic [CAUSE_WIDTH-1:0] CAUSE_TIMEOUT = 2'd2;

    // Register reset values.
    localparam logic [TIMEOUT_WIDTH-1:0] TIMEOUT_RESET = '1;
    localparam logic [WARNING_WIDTH-1:0] WARNING_RESET = WARNING_WIDTH'(40 * 1000);

    typedef struct packed {
        logic begin_req;
        logic left_level;
        logic right_level;
    } in_word_t;

    typedef struct packed {
        logic                   stopped;
        logic [CAUSE_WIDTH-1:0] stop_cause;
        logic [EDGES_WIDTH-1:0] left_edges;
        logic [EDGES_WIDTH-1:0] right_edges;
    } out_word_t;

endpackage

// ----- hdl/encoder_edge_count_early_stop.sv -----
// ----------------------------------------------------------------------------
// Encoder edge counter with early stop
// Counts level changes of two encoder wheels per microsecond tick and stops a
// run on an early warning of the tracked wheel or on timeout.
// ----------------------------------------------------------------------------
// Usage.
// Each input word is one microsecond tick holding both sampled wheel levels
// and a begin flag; begin clears the counts, the timers and any stop before
// the tick itself is handled. Every accepted input word yields exactly one
// output word with the stop flag, the stop cause and both edge counts.
// Both channels use valid and stall; a word moves on a rising edge where
// valid is high and stall is low.
// Results go to the output register, or to the skid register while it holds
// a stalled result. Throughput is one word per cycle while the skid register
// is free; a single pass of logic, whose longest path is the 16 by 24 bit
// product of remaining edges and edge interval, updates the run state.
// When the receiver stalls, the held result stays on out_data and a second
// result is caught in a skid register, so one further word is still taken.
// in_stall rises only while the skid register is occupied.
// Configuration registers are written through cfg_write, cfg_index and
// cfg_data, and must only be changed while the block is idle.
// Reset clears the run state and the valid flags of the output and skid
// registers, and loads the register reset values (timeout all ones, warning
// 40000 ticks).
// ----------------------------------------------------------------------------
module encoder_edge_count_early_stop #(
    parameter int COUNT_WIDTH = ecnt_pkg::COUNT_WIDTH_DEFAULT,
    parameter int TIME_WIDTH  = ecnt_pkg::TIME_WIDTH_DEFAULT
) (
    input  logic                                 clk,
    input  logic                                 rst_n,

    input  logic                                 cfg_write,
    input  logic [ecnt_pkg::CFG_IDX_WIDTH-1:0]   cfg_index,
    input  logic [ecnt_pkg::CFG_WIDTH-1:0]       cfg_data,

    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  ecnt_pkg::in_word_t                   in_data,

    output logic                                 out_valid,
    input  logic                                 out_stall,
    output ecnt_pkg::out_word_t                  out_data
);

    // Comparison widths that cover both the internal counter and the
    // fixed-width register it is compared against.
    localparam int CNT_EXT_WIDTH  = (COUNT_WIDTH > ecnt_pkg::TARGET_WIDTH) ?
                                    COUNT_WIDTH : ecnt_pkg::TARGET_WIDTH;
    localparam int INT_EXT_WIDTH  = (TIME_WIDTH > ecnt_pkg::WARNING_WIDTH) ?
                                    TIME_WIDTH : ecnt_pkg::WARNING_WIDTH;
    localparam int TO_EXT_WIDTH   = (TIME_WIDTH > ecnt_pkg::TIMEOUT_WIDTH) ?
                                    TIME_WIDTH : ecnt_pkg::TIMEOUT_WIDTH;
    localparam int PRODUCT_WIDTH  = ecnt_pkg::TARGET_WIDTH + ecnt_pkg::WARNING_WIDTH;

    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;
    localparam logic [TIME_WIDTH-1:0]  TIME_MAX  = '1;

    // Configuration registers.
    logic [ecnt_pkg::CHANNEL_WIDTH-1:0] tracked_channel_reg;
    logic [ecnt_pkg::TARGET_WIDTH-1:0]  target_count_reg;
    logic [ecnt_pkg::TIMEOUT_WIDTH-1:0] timeout_ticks_reg;
    logic [ecnt_pkg::WARNING_WIDTH-1:0] warning_ticks_reg;

    // Run state, one entry per wheel where it applies (0 left, 1 right).
    logic [1:0]                          prev_level_reg, prev_level_next;
    logic [1:0][COUNT_WIDTH-1:0]         edge_count_reg, edge_count_next;
    logic [1:0][TIME_WIDTH-1:0]          since_edge_reg, since_edge_next;
    logic [TIME_WIDTH-1:0]               elapsed_reg, elapsed_next;
    logic                                done_reg, done_next;
    logic [ecnt_pkg::CAUSE_WIDTH-1:0]    cause_reg, cause_next;

    // Output register and skid register.
    logic                                out_valid_reg;
    ecnt_pkg::out_word_t                 out_data_reg;
    logic                                skid_valid_reg;
    ecnt_pkg::out_word_t                 skid_data_reg;
    ecnt_pkg::out_word_t                 result;

    logic                                in_take;
    logic                                out_take;

    // Per-wheel working values of the single pass.
    logic [1:0]                          level;
    logic [1:0]                          edge_seen;
    logic [1:0]                          warn_hit;
    logic [1:0][COUNT_WIDTH-1:0]         count_base;
    logic [1:0][COUNT_WIDTH-1:0]         count_inc;
    logic [1:0][TIME_WIDTH-1:0]          interval;
    logic [1:0][CNT_EXT_WIDTH-1:0]       count_ext;
    logic [1:0][INT_EXT_WIDTH-1:0]       interval_ext;
    logic [1:0][ecnt_pkg::TARGET_WIDTH-1:0] remaining;
    logic [1:0][PRODUCT_WIDTH-1:0]       product;
    logic                                run_active;
    logic                                left_warn;
    logic                                right_warn;
    logic [TIME_WIDTH-1:0]               elapsed_inc;
    logic [CNT_EXT_WIDTH-1:0]            left_edges_ext;
    logic [CNT_EXT_WIDTH-1:0]            right_edges_ext;

    assign in_take   = in_valid && !skid_valid_reg;
    assign out_take  = out_valid_reg && !out_stall;
    assign in_stall  = skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    assign level = {in_data.right_level, in_data.left_level};

    // A begin clears the run before this tick is handled, so the values the
    // tick works from are either the held state or all zero.
    always_comb
    begin
        run_active  = in_data.begin_req || !done_reg;
        elapsed_inc = in_data.begin_req ? TIME_WIDTH'(1) :
                      (elapsed_reg == TIME_MAX) ? TIME_MAX : elapsed_reg + 1'b1;
        for (int w = 0; w < 2; w++)
        begin
            count_base[w]   = in_data.begin_req ? '0 : edge_count_reg[w];
            edge_seen[w]    = level[w] != (in_data.begin_req ? 1'b0 : prev_level_reg[w]);
            count_inc[w]    = (count_base[w] == COUNT_MAX) ? COUNT_MAX
                                                            : count_base[w] + 1'b1;
            interval[w]     = in_data.begin_req ? TIME_WIDTH'(1) :
                              (since_edge_reg[w] == TIME_MAX) ? TIME_MAX
                                                              : since_edge_reg[w] + 1'b1;
            count_ext[w]    = CNT_EXT_WIDTH'(count_inc[w]);
            interval_ext[w] = INT_EXT_WIDTH'(interval[w]);
            remaining[w]    = target_count_reg
                              - count_ext[w][ecnt_pkg::TARGET_WIDTH-1:0];
            product[w]      = PRODUCT_WIDTH'(remaining[w])
                              * PRODUCT_WIDTH'(interval_ext[w][ecnt_pkg::WARNING_WIDTH-1:0]);
            // At or past the target the remaining count is not positive, so the
            // warning fires outright; an interval above the warning time
            // can never predict a short enough remainder.
            if (count_ext[w] >= CNT_EXT_WIDTH'(target_count_reg))
            begin
                warn_hit[w] = 1'b1;
            end
            else if (interval_ext[w] > INT_EXT_WIDTH'(warning_ticks_reg))
            begin
                warn_hit[w] = 1'b0;
            end
            else
            begin
                warn_hit[w] = product[w] <= PRODUCT_WIDTH'(warning_ticks_reg);
            end
        end
    end

    always_comb
    begin
        prev_level_next = prev_level_reg;
        edge_count_next = edge_count_reg;
        since_edge_next = since_edge_reg;
        elapsed_next    = elapsed_reg;
        done_next       = done_reg;
        cause_next      = cause_reg;
        left_warn       = 1'b0;
        right_warn      = 1'b0;

        if (in_data.begin_req)
        begin
            prev_level_next = '0;
            edge_count_next = '0;
            since_edge_next = '0;
            elapsed_next    = '0;
            done_next       = 1'b0;
            cause_next      = ecnt_pkg::CAUSE_RUNNING;
        end

        if (run_active)
        begin
            elapsed_next    = elapsed_inc;
            since_edge_next = interval;
            prev_level_next = level;

            if (edge_seen[0])
            begin
                edge_count_next[0] = count_inc[0];
                since_edge_next[0] = '0;
                left_warn = warn_hit[0] && (tracked_channel_reg == ecnt_pkg::CHANNEL_LEFT);
            end

            // A left warning ends the tick before the right edge is taken.
            if (edge_seen[1] && !left_warn)
            begin
                edge_count_next[1] = count_inc[1];
                since_edge_next[1] = '0;
                right_warn = warn_hit[1] && (tracked_channel_reg == ecnt_pkg::CHANNEL_RIGHT);
            end

            if (left_warn || right_warn)
            begin
                done_next  = 1'b1;
                cause_next = ecnt_pkg::CAUSE_WARNING;
            end
            else if (TO_EXT_WIDTH'(elapsed_inc) > TO_EXT_WIDTH'(timeout_ticks_reg))
            begin
                done_next  = 1'b1;
                cause_next = ecnt_pkg::CAUSE_TIMEOUT;
            end
        end
    end

    // The reported counts are the low bits of the counters.
    always_comb
    begin
        left_edges_ext     = CNT_EXT_WIDTH'(edge_count_next[0]);
        right_edges_ext    = CNT_EXT_WIDTH'(edge_count_next[1]);
        result.stopped     = done_next;
        result.stop_cause  = cause_next;
        result.left_edges  = left_edges_ext[ecnt_pkg::EDGES_WIDTH-1:0];
        result.right_edges = right_edges_ext[ecnt_pkg::EDGES_WIDTH-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tracked_channel_reg <= ecnt_pkg::CHANNEL_LEFT;
            target_count_reg    <= '0;
            timeout_ticks_reg   <= ecnt_pkg::TIMEOUT_RESET;
            warning_ticks_reg   <= ecnt_pkg::WARNING_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                ecnt_pkg::REG_TRACKED_CHANNEL:
                    tracked_channel_reg <= cfg_data[ecnt_pkg::CHANNEL_WIDTH-1:0];
                ecnt_pkg::REG_TARGET_COUNT:
                    target_count_reg <= cfg_data[ecnt_pkg::TARGET_WIDTH-1:0];
                ecnt_pkg::REG_TIMEOUT_TICKS:
                    timeout_ticks_reg <= cfg_data[ecnt_pkg::TIMEOUT_WIDTH-1:0];
                ecnt_pkg::REG_WARNING_TICKS:
                    warning_ticks_reg <= cfg_data[ecnt_pkg::WARNING_WIDTH-1:0];
                default:
                    tracked_channel_reg <= tracked_channel_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_level_reg <= '0;
            edge_count_reg <= '0;
            since_edge_reg <= '0;
            elapsed_reg    <= '0;
            done_reg       <= 1'b0;
            cause_reg      <= ecnt_pkg::CAUSE_RUNNING;
        end
        else if (in_take)
        begin
            prev_level_reg <= prev_level_next;
            edge_count_reg <= edge_count_next;
            since_edge_reg <= since_edge_next;
            elapsed_reg    <= elapsed_next;
            done_reg       <= done_next;
            cause_reg      <= cause_next;
        end
    end

    // Output register with a skid register behind it. Input words are only
    // taken while the skid register is free.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (out_take)
        begin
            out_valid_reg  <= skid_valid_reg || in_take;
            skid_valid_reg <= 1'b0;
        end
        else if (in_take)
        begin
            out_valid_reg  <= 1'b1;
            skid_valid_reg <= out_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_take)
        begin
            out_data_reg <= skid_valid_reg ? skid_data_reg : result;
        end
        else if (in_take && !out_valid_reg)
        begin
            out_data_reg <= result;
        end

        if (in_take && out_valid_reg && !out_take)
        begin
            skid_data_reg <= result;
        end
    end

endmodule

// ----- hdl/ecnt_checker.sv -----
// ----------------------------------------------------------------------------
// Encoder edge counter checker
// Port-level assertions for the encoder edge counter, bound to its top level.
// ----------------------------------------------------------------------------
module ecnt_checker (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    input  logic                                 in_stall,
    input  logic                                 out_valid,
    input  logic                                 out_stall,
    input  ecnt_pkg::out_word_t                  out_data
);

    // A stalled result word stays offered and unchanged.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("stalled output word changed or was dropped");

    // Every accepted tick is followed by a valid output word on the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> out_valid)
        else $error("accepted tick produced no output word");

    // The input side is only held back while a result is waiting.
    assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> !in_stall)
        else $error("input stalled with no pending output word");

    // The stop flag and the stop cause agree.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_data.stopped == (out_data.stop_cause != ecnt_pkg::CAUSE_RUNNING)))
        else $error("stop flag and stop cause disagree");

endmodule

bind encoder_edge_count_early_stop ecnt_checker u_ecnt_checker (.*);

// ----- dv/encoder_edge_count_early_stop_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Encoder edge counter with early stop: block-level test
// Drives tick words through the valid/stall input channel with random gaps.
// Each accepted word is run through a local model of the counter, which gives
// the expected output word. Separate processes stall the output channel at
// random and check every result word against the oldest expected word.
// ----------------------------------------------------------------------------
module encoder_edge_count_early_stop_test;

    // Tracked wheel codes that disable the warning check. The package only
    // names the two wheels, so the two spare codes are named here.
    localparam logic [ecnt_pkg::CHANNEL_WIDTH-1:0] CHANNEL_NONE  = 2'd2;
    localparam logic [ecnt_pkg::CHANNEL_WIDTH-1:0] CHANNEL_SPARE = 2'd3;

    localparam int MAX_REPORTS = 10;

    logic                               clk;
    logic                               rst_n;
    logic                               cfg_write;
    logic [ecnt_pkg::CFG_IDX_WIDTH-1:0] cfg_index;
    logic [ecnt_pkg::CFG_WIDTH-1:0]     cfg_data;
    logic                               in_valid;
    logic                               in_stall;
    ecnt_pkg::in_word_t                 in_data;
    logic                               out_valid;
    logic                               out_stall;
    ecnt_pkg::out_word_t                out_data;

    encoder_edge_count_early_stop dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    // ------------------------------------------------------------------------
    // Local copy of the register file and of the run state.
    // ------------------------------------------------------------------------
    logic [ecnt_pkg::CHANNEL_WIDTH-1:0] cfg_channel = ecnt_pkg::CHANNEL_LEFT;
    logic [ecnt_pkg::TARGET_WIDTH-1:0]  cfg_target  = '0;
    logic [ecnt_pkg::TIMEOUT_WIDTH-1:0] cfg_timeout = ecnt_pkg::TIMEOUT_RESET;
    logic [ecnt_pkg::WARNING_WIDTH-1:0] cfg_warning = ecnt_pkg::WARNING_RESET;

    logic                               prev_lvl [2];
    logic [ecnt_pkg::EDGES_WIDTH-1:0]   edge_cnt [2];
    logic [31:0]                        since_edge [2];
    logic [31:0]                        elapsed;
    logic                               run_done;
    logic [ecnt_pkg::CAUSE_WIDTH-1:0]   run_cause;

    // Output words still owed by the block, oldest first.
    ecnt_pkg::out_word_t expected_words [$];
    int                  faults;

    // When set, neither side idles; this gives back-to-back stretches.
    bit calm;

    // ------------------------------------------------------------------------
    // Model of the block
    // ------------------------------------------------------------------------
    function automatic void clear_run();
        for (int w = 0; w < 2; w++)
        begin
            prev_lvl[w]   = 1'b0;
            edge_cnt[w]   = '0;
            since_edge[w] = '0;
        end
        elapsed   = '0;
        run_done  = 1'b0;
        run_cause = ecnt_pkg::CAUSE_RUNNING;
    endfunction

    function automatic logic [31:0] step_timer(input logic [31:0] v);
        return (v == '1) ? v : v + 32'd1;
    endfunction

    // Counts an edge of wheel w and says whether it ends the run with a
    // warning. The interval is the time since the wheel's previous edge.
    function automatic bit wheel_edge(input int w);
        logic [31:0]                      interval;
        logic [ecnt_pkg::EDGES_WIDTH-1:0] to_go;
        logic [63:0]                      remaining;
        interval      = since_edge[w];
        edge_cnt[w]   = (edge_cnt[w] == '1) ? edge_cnt[w] : edge_cnt[w] + 1'b1;
        since_edge[w] = '0;
        if (cfg_channel != ecnt_pkg::CHANNEL_WIDTH'(w))
            return 1'b0;
        if (edge_cnt[w] >= cfg_target)
            return 1'b1;
        if (interval > 32'(cfg_warning))
            return 1'b0;
        to_go     = cfg_target - edge_cnt[w];
        remaining = 64'(to_go) * 64'(interval);
        return remaining <= 64'(cfg_warning);
    endfunction

    function automatic ecnt_pkg::out_word_t predict_tick(input ecnt_pkg::in_word_t w);
        ecnt_pkg::out_word_t res;
        bit                  warn;
        if (w.begin_req)
            clear_run();
        if (!run_done)
        begin
            warn          = 1'b0;
            elapsed       = step_timer(elapsed);
            since_edge[0] = step_timer(since_edge[0]);
            since_edge[1] = step_timer(since_edge[1]);
            // The left wheel goes first; a left warning hides the right edge.
            if (w.left_level != prev_lvl[0])
                warn = wheel_edge(0);
            if (!warn && w.right_level != prev_lvl[1])
                warn = wheel_edge(1);
            prev_lvl[0] = w.left_level;
            prev_lvl[1] = w.right_level;
            if (warn)
            begin
                run_done  = 1'b1;
                run_cause = ecnt_pkg::CAUSE_WARNING;
            end
            else if (elapsed > cfg_timeout)
            begin
                run_done  = 1'b1;
                run_cause = ecnt_pkg::CAUSE_TIMEOUT;
            end
        end
        res.stopped     = run_done;
        res.stop_cause  = run_cause;
        res.left_edges  = edge_cnt[0];
        res.right_edges = edge_cnt[1];
        return res;
    endfunction

    // Idle length for either side: mostly none or short, now and then long.
    function automatic int pick_gap();
        int r;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // ------------------------------------------------------------------------
    // Clock, reset and watchdog
    // ------------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // The slowest correct run is a few milliseconds; this allows several times
    // that before the run is declared hung.
    initial
    begin
        #20_000_000;
        $display("Some tests failed");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Output side: random stalls, and the check of every word that moves.
    // ------------------------------------------------------------------------
    initial
    begin
        int hold;
        int ready;
        out_stall <= 1'b0;
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            hold = pick_gap();
            if (hold > 0)
            begin
                out_stall <= 1'b1;
                repeat (hold) @(posedge clk);
                out_stall <= 1'b0;
            end
            ready = $urandom_range(1, 6);
            repeat (ready) @(posedge clk);
        end
    end

    task automatic report_fault(input string what, input ecnt_pkg::out_word_t want,
                                input ecnt_pkg::out_word_t got);
        faults++;
        if (faults <= MAX_REPORTS)
            $display("%0t: %s: expected stopped=%0d cause=%0d left=%0d right=%0d",
                     $realtime, what, want.stopped, want.stop_cause, want.left_edges,
                     want.right_edges,
                     ", got stopped=%0d cause=%0d left=%0d right=%0d",
                     got.stopped, got.stop_cause, got.left_edges, got.right_edges);
    endtask

    // Values are read at the edge itself, before any assignment made at that
    // edge has landed, so the order of processes within the step is of no
    // consequence.
    always @(posedge clk)
    begin
        ecnt_pkg::out_word_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_words.size() == 0)
                report_fault("word with nothing expected", '0, out_data);
            else
            begin
                want = expected_words.pop_front();
                if (out_data.stopped !== want.stopped
                    || out_data.stop_cause !== want.stop_cause
                    || out_data.left_edges !== want.left_edges
                    || out_data.right_edges !== want.right_edges)
                    report_fault("mismatch", want, out_data);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Input side
    // ------------------------------------------------------------------------

    // Offers one tick word and returns at the edge at which it is taken, with
    // valid still high so that a following word can go out at once.
    task automatic send_tick(input ecnt_pkg::in_word_t w);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= w;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        expected_words.push_back(predict_tick(w));
    endtask

    task automatic send_levels(input logic bgn, input logic lft, input logic rgt);
        ecnt_pkg::in_word_t w;
        w.begin_req   = bgn;
        w.left_level  = lft;
        w.right_level = rgt;
        send_tick(w);
    endtask

    // Stops offering words and waits until every result has come back. Each
    // word gives exactly one result, so the block is idle at that point.
    task automatic settle();
        in_valid <= 1'b0;
        while (expected_words.size() != 0)
            @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    task automatic write_reg(input logic [ecnt_pkg::CFG_IDX_WIDTH-1:0] idx,
                             input logic [ecnt_pkg::CFG_WIDTH-1:0] val);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        case (idx)
            ecnt_pkg::REG_TRACKED_CHANNEL:
                cfg_channel = val[ecnt_pkg::CHANNEL_WIDTH-1:0];
            ecnt_pkg::REG_TARGET_COUNT:
                cfg_target  = val[ecnt_pkg::TARGET_WIDTH-1:0];
            ecnt_pkg::REG_TIMEOUT_TICKS:
                cfg_timeout = val[ecnt_pkg::TIMEOUT_WIDTH-1:0];
            default:
                cfg_warning = val[ecnt_pkg::WARNING_WIDTH-1:0];
        endcase
    endtask

    // Writes all four registers back to back once the block has gone idle.
    task automatic set_config(input logic [ecnt_pkg::CFG_WIDTH-1:0] channel,
                              input logic [ecnt_pkg::CFG_WIDTH-1:0] target,
                              input logic [ecnt_pkg::CFG_WIDTH-1:0] timeout,
                              input logic [ecnt_pkg::CFG_WIDTH-1:0] warning);
        settle();
        write_reg(ecnt_pkg::REG_TRACKED_CHANNEL, channel);
        write_reg(ecnt_pkg::REG_TARGET_COUNT, target);
        write_reg(ecnt_pkg::REG_TIMEOUT_TICKS, timeout);
        write_reg(ecnt_pkg::REG_WARNING_TICKS, warning);
        cfg_write <= 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // Directed tests
    // ------------------------------------------------------------------------

    // Register reset values: the left wheel is tracked with a target of zero,
    // so its first edge stops the run. Later ticks are ignored until begin,
    // and a pin that is high on the begin tick counts as an edge.
    task automatic test_reset_defaults();
        send_levels(1'b1, 1'b0, 1'b0);
        send_levels(1'b0, 1'b1, 1'b0);
        send_levels(1'b0, 1'b0, 1'b1);
        send_levels(1'b1, 1'b0, 1'b1);
    endtask

    // A zero limit ends the run on its first tick; a limit of two ends it on
    // the third, with the edges of that tick still counted.
    task automatic test_timeout();
        set_config(CHANNEL_NONE, 0, 0, 0);
        send_levels(1'b1, 1'b0, 1'b0);
        set_config(CHANNEL_SPARE, 0, 2, '1);
        send_levels(1'b1, 1'b1, 1'b1);
        send_levels(1'b0, 1'b0, 1'b0);
        send_levels(1'b0, 1'b1, 1'b1);
    endtask

    // A left warning leaves the right edge of the same tick uncounted. With
    // the right wheel tracked, the warning comes once the predicted time is
    // small enough or the target has been reached.
    task automatic test_warning_order();
        set_config(ecnt_pkg::CHANNEL_LEFT, 3, '1, 24'hFF_FFFF);
        send_levels(1'b1, 1'b1, 1'b1);
        set_config(ecnt_pkg::CHANNEL_RIGHT, 3, '1, 1);
        send_levels(1'b1, 1'b1, 1'b1);
        send_levels(1'b0, 1'b1, 1'b1);
        send_levels(1'b0, 1'b0, 1'b0);
        send_levels(1'b0, 1'b1, 1'b1);
    endtask

    // Extremes of the warning time, the full target, and an interval beyond
    // the warning time.
    task automatic test_warning_bounds();
        set_config(ecnt_pkg::CHANNEL_LEFT, 16'hFFFF, '1, 0);
        send_levels(1'b1, 1'b1, 1'b0);
        send_levels(1'b0, 1'b0, 1'b0);
        set_config(ecnt_pkg::CHANNEL_LEFT, 16'hFFFF, '1, 24'hFF_FFFF);
        send_levels(1'b1, 1'b1, 1'b0);
        set_config(ecnt_pkg::CHANNEL_LEFT, 2, '1, 2);
        send_levels(1'b1, 1'b0, 1'b0);
        send_levels(1'b0, 1'b0, 1'b0);
        send_levels(1'b0, 1'b0, 1'b0);
        send_levels(1'b0, 1'b1, 1'b0);
    endtask

    // Both wheels toggle on every tick with neither side idling, so words
    // follow back to back and both counts climb on every tick.
    task automatic test_steady_toggle();
        logic lvl;
        set_config(CHANNEL_NONE, 0, '1, 0);
        calm = 1'b1;
        lvl  = 1'b1;
        send_levels(1'b1, lvl, lvl);
        for (int k = 0; k < 99; k++)
        begin
            lvl = ~lvl;
            send_levels(1'b0, lvl, lvl);
        end
        calm = 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // Random runs
    // ------------------------------------------------------------------------

    // Picks a setting weighted towards values that make stops likely, with
    // random junk above each register's width.
    task automatic random_config();
        logic [ecnt_pkg::CFG_WIDTH-1:0] junk;
        logic [ecnt_pkg::CFG_WIDTH-1:0] target;
        logic [ecnt_pkg::CFG_WIDTH-1:0] timeout;
        logic [ecnt_pkg::CFG_WIDTH-1:0] warning;
        int                             r;
        junk = $urandom;
        r = $urandom_range(0, 99);
        if (r < 30)
            target = $urandom_range(0, 8);
        else if (r < 60)
            target = $urandom_range(8, 64);
        else if (r < 75)
            target = $urandom_range(0, 1) ? 32'h0000_FFFF : 32'd0;
        else
            target = $urandom_range(0, 16'hFFFF);
        r = $urandom_range(0, 99);
        if (r < 20)
            timeout = $urandom_range(0, 20);
        else if (r < 60)
            timeout = $urandom_range(20, 300);
        else if (r < 80)
            timeout = '1;
        else
            timeout = $urandom;
        r = $urandom_range(0, 99);
        if (r < 30)
            warning = $urandom_range(0, 50);
        else if (r < 55)
            warning = $urandom_range(50, 2000);
        else if (r < 70)
            warning = $urandom_range(0, 1) ? 32'h00FF_FFFF : 32'd0;
        else
            warning = $urandom_range(0, 24'hFF_FFFF);
        set_config({junk[31:2], 2'($urandom_range(0, 3))},
                   {junk[31:16], target[15:0]}, timeout,
                   {junk[31:24], warning[23:0]});
    endtask

    // Each run opens with begin and then feeds encoder-like square waves of
    // random period on both wheels. Some samples are noise, a few runs lack
    // the begin word, and a stray begin now and then cuts a run short. Words
    // that a stopped run merely ignores are not counted.
    task automatic test_random_runs(input int phases, input int per_phase);
        ecnt_pkg::in_word_t w;
        int                 sent;
        int                 run_len;
        int                 period_l;
        int                 period_r;
        int                 count_l;
        int                 count_r;
        logic               lvl_l;
        logic               lvl_r;
        for (int p = 0; p < phases; p++)
        begin
            random_config();
            calm = (p % 4 == 3);
            sent = 0;
            while (sent < per_phase)
            begin
                period_l = $urandom_range(1, 40);
                period_r = $urandom_range(1, 40);
                count_l  = 0;
                count_r  = 0;
                lvl_l    = $urandom_range(0, 1);
                lvl_r    = $urandom_range(0, 1);
                run_len  = $urandom_range(4, 90);
                for (int k = 0; k < run_len && sent < per_phase; k++)
                begin
                    if (k == 0)
                        w.begin_req = ($urandom_range(0, 9) != 0);
                    else
                        w.begin_req = ($urandom_range(0, 99) < 2);
                    if ($urandom_range(0, 9) == 0)
                    begin
                        lvl_l = $urandom_range(0, 1);
                        lvl_r = $urandom_range(0, 1);
                    end
                    else
                    begin
                        count_l++;
                        count_r++;
                        if (count_l >= period_l)
                        begin
                            count_l = 0;
                            lvl_l   = ~lvl_l;
                        end
                        if (count_r >= period_r)
                        begin
                            count_r = 0;
                            lvl_r   = ~lvl_r;
                        end
                    end
                    w.left_level  = lvl_l;
                    w.right_level = lvl_r;
                    if (w.begin_req || !run_done)
                        sent++;
                    send_tick(w);
                    // Once stopped, usually move on to a fresh run.
                    if (run_done && $urandom_range(0, 2) != 0)
                        break;
                end
            end
        end
        calm = 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // Sequence of tests
    // ------------------------------------------------------------------------
    initial
    begin
        faults    = 0;
        calm      = 1'b0;
        clear_run();
        rst_n     <= 1'b0;
        cfg_write <= 1'b0;
        cfg_index <= ecnt_pkg::REG_TRACKED_CHANNEL;
        cfg_data  <= '0;
        in_valid  <= 1'b0;
        in_data   <= '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_defaults();
        test_timeout();
        test_warning_order();
        test_warning_bounds();
        test_steady_toggle();
        test_random_runs(8, 150);

        settle();
        if (faults == 0 && expected_words.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
